// ----- rtl/fsk_tx_bit_framer_assert.svh -----
// Assertion macros used by the FSK transmit bit framer datapath.
`ifndef FSK_TX_BIT_FRAMER_ASSERT_SVH
`define FSK_TX_BIT_FRAMER_ASSERT_SVH

// Check that a condition implies another one in the same cycle.
`define FSKTX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fsktx: same-cycle check failed");

// Check that a condition implies another one in the next cycle.
`define FSKTX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fsktx: next-cycle check failed");

`endif

// ----- rtl/fsktx_pkg.sv -----
// Shared types, constants and the line mode table of the FSK transmit bit framer.
package fsktx_pkg;

  // Sample rate of the tone generator that follows this block
  localparam int unsigned SAMPLE_RATE = 9600;

  // Character request codes
  typedef enum logic [2:0] {
    OP_ASYNC_DATA = 3'd0,
    OP_ASYNC_IDLE = 3'd1,
    OP_SYNC_DATA  = 3'd2,
    OP_SYNC_FLAG  = 3'd3,
    OP_SYNC_ABORT = 3'd4
  } op_e;

  // Fixed line patterns
  localparam logic [9:0] ASYNC_IDLE_WORD = 10'h3ff;
  localparam logic [7:0] SYNC_FLAG_BYTE  = 8'h7e;
  localparam logic [7:0] SYNC_ABORT_BYTE = 8'h7f;
  localparam logic [4:0] STUFF_PATTERN   = 5'h1f;
  localparam logic [3:0] ASYNC_BITS      = 4'd10;
  localparam logic [3:0] SYNC_BITS       = 4'd8;

  // Tones per mode
  localparam logic [11:0] V21O_SPACE_HZ = 12'd1180;
  localparam logic [11:0] V21O_MARK_HZ  = 12'd980;
  localparam logic [11:0] V21A_SPACE_HZ = 12'd1850;
  localparam logic [11:0] V21A_MARK_HZ  = 12'd1650;
  localparam logic [11:0] V23O_SPACE_HZ = 12'd450;
  localparam logic [11:0] V23O_MARK_HZ  = 12'd390;
  localparam logic [11:0] HS_SPACE_HZ   = 12'd2100;
  localparam logic [11:0] HS_MARK_HZ    = 12'd1300;

  // Bit lengths in samples, kept to eleven bits
  localparam logic [10:0] SPB_300  = 11'(SAMPLE_RATE / 300);
  localparam logic [10:0] SPB_75   = 11'(SAMPLE_RATE / 75);
  localparam logic [10:0] SPB_1200 = 11'(SAMPLE_RATE / 1200);

  // Line mode codes
  localparam logic [2:0] MODE_V21_ORIG = 3'd0;
  localparam logic [2:0] MODE_V21_ANS  = 3'd1;
  localparam logic [2:0] MODE_V23_ORIG = 3'd2;

  typedef struct packed {
    logic [10:0] spb;
    logic [11:0] space_hz;
    logic [11:0] mark_hz;
  } mode_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic emit_bit;
    logic emit_stuff;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic stuff_needed;
    logic data_last;
    logic stuff_last;
  } status_t;

  // Look up tones and bit length; every 1200 bps mode and unused codes share one entry
  function automatic mode_entry_t mode_lookup(logic [2:0] mode);
    mode_entry_t e;
    case (mode)
      MODE_V21_ORIG: e = '{spb: SPB_300,  space_hz: V21O_SPACE_HZ, mark_hz: V21O_MARK_HZ};
      MODE_V21_ANS:  e = '{spb: SPB_300,  space_hz: V21A_SPACE_HZ, mark_hz: V21A_MARK_HZ};
      MODE_V23_ORIG: e = '{spb: SPB_75,   space_hz: V23O_SPACE_HZ, mark_hz: V23O_MARK_HZ};
      default:       e = '{spb: SPB_1200, space_hz: HS_SPACE_HZ,   mark_hz: HS_MARK_HZ};
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/fsktx_datapath.sv -----
// Datapath of the FSK transmit bit framer: bit shifter, history, mode register, output register.
`include "fsk_tx_bit_framer_assert.svh"

module fsktx_datapath import fsktx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_bit_o,
  output logic [11:0] tone_hz_o,
  output logic [10:0] samples_per_bit_o,
  output logic        last_bit_o
);

  logic [2:0]  line_mode_q;
  logic [9:0]  word_q, word_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [4:0]  hist_q, hist_d;
  logic        lsb_first_q, lsb_first_d;
  logic        stuff_en_q, stuff_en_d;
  logic        out_valid_q, out_valid_d;
  logic        out_bit_q, out_last_q;
  logic [11:0] out_tone_q;
  logic [10:0] out_spb_q;

  logic        cur_bit;
  logic [4:0]  hist_next;
  logic        emit;
  logic        emit_val;
  logic        emit_last;
  mode_entry_t entry;

  // Pick the next bit and the history it would leave
  assign cur_bit   = lsb_first_q ? word_q[0] : word_q[7];
  assign hist_next = {hist_q[3:0], cur_bit};
  assign entry     = mode_lookup(line_mode_q);

  assign status_o.slot_free    = !out_valid_q || out_ready_i;
  assign status_o.stuff_needed = stuff_en_q && (hist_next == STUFF_PATTERN);
  assign status_o.data_last    = (cnt_q == 4'd1);
  assign status_o.stuff_last   = (cnt_q == 4'd0);

  assign emit      = cmd_i.emit_bit || cmd_i.emit_stuff;
  assign emit_val  = cmd_i.emit_bit ? cur_bit : 1'b0;
  assign emit_last = cmd_i.emit_bit ? (status_o.data_last && !status_o.stuff_needed)
                                    : status_o.stuff_last;

  // Load a character, advance the shifter on a data bit, or shift a stuffed zero into the history
  always_comb begin
    word_d      = word_q;
    cnt_d       = cnt_q;
    lsb_first_d = lsb_first_q;
    stuff_en_d  = stuff_en_q;
    hist_d      = hist_q;
    if (cmd_i.load) begin
      lsb_first_d = 1'b0;
      stuff_en_d  = 1'b0;
      cnt_d       = SYNC_BITS;
      word_d      = {2'b00, data_byte_i};
      case (operation_i)
        OP_ASYNC_DATA: begin
          word_d      = {1'b1, data_byte_i, 1'b0};
          lsb_first_d = 1'b1;
          cnt_d       = ASYNC_BITS;
        end
        OP_ASYNC_IDLE: begin
          word_d      = ASYNC_IDLE_WORD;
          lsb_first_d = 1'b1;
          cnt_d       = ASYNC_BITS;
        end
        OP_SYNC_DATA: begin
          stuff_en_d = 1'b1;
        end
        OP_SYNC_FLAG: begin
          word_d = {2'b00, SYNC_FLAG_BYTE};
        end
        OP_SYNC_ABORT: begin
          word_d = {2'b00, SYNC_ABORT_BYTE};
        end
        default: begin
          word_d = word_q;
        end
      endcase
    end else if (cmd_i.emit_bit) begin
      word_d = lsb_first_q ? {1'b0, word_q[9:1]} : {word_q[8:0], 1'b0};
      cnt_d  = cnt_q - 4'd1;
      hist_d = hist_next;
    end else if (cmd_i.emit_stuff) begin
      hist_d = {hist_q[3:0], 1'b0};
    end
  end

  // Hold the result until the downstream side takes it
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q <= 3'd0;
      hist_q      <= 5'd0;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_mode_q <= cfg_data_i;
      end
      hist_q      <= hist_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    lsb_first_q <= lsb_first_d;
    stuff_en_q  <= stuff_en_d;
    if (emit) begin
      out_bit_q  <= emit_val;
      out_last_q <= emit_last;
      out_tone_q <= emit_val ? entry.mark_hz : entry.space_hz;
      out_spb_q  <= entry.spb;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign line_bit_o        = out_bit_q;
  assign tone_hz_o         = out_tone_q;
  assign samples_per_bit_o = out_spb_q;
  assign last_bit_o        = out_last_q;

  // A bit is only produced into a free output register
  `FSKTX_ASSERT_IMP(a_emit_slot_free, emit, status_o.slot_free)
  // A stuffed zero follows only five ones in the history
  `FSKTX_ASSERT_IMP(a_stuff_after_ones, cmd_i.emit_stuff, hist_q == STUFF_PATTERN)
  // A data bit never runs past the end of the character
  `FSKTX_ASSERT_IMP(a_bits_remain, cmd_i.emit_bit, cnt_q != 4'd0)
  // Every produced bit is offered downstream in the next cycle
  `FSKTX_ASSERT_NEXT(a_emit_shows, emit, out_valid_q)

endmodule

// ----- rtl/fsktx_ctrl.sv -----
// Controller of the FSK transmit bit framer: sequences the bits of one character.
module fsktx_ctrl import fsktx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BIT   = 3'b010,
    ST_STUFF = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   op_known;

  assign in_ready_o = (state_q == ST_IDLE);

  // Flag requests that produce line bits
  always_comb begin
    case (operation_i)
      OP_ASYNC_DATA, OP_ASYNC_IDLE, OP_SYNC_DATA, OP_SYNC_FLAG, OP_SYNC_ABORT:
        op_known = 1'b1;
      default:
        op_known = 1'b0;
    endcase
  end

  // Step through data bits and stuffed zeros
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && op_known) begin
          cmd_o.load = 1'b1;
          state_d    = ST_BIT;
        end
      end
      ST_BIT: begin
        if (status_i.slot_free) begin
          cmd_o.emit_bit = 1'b1;
          if (status_i.stuff_needed) begin
            state_d = ST_STUFF;
          end else if (status_i.data_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STUFF: begin
        if (status_i.slot_free) begin
          cmd_o.emit_stuff = 1'b1;
          state_d = status_i.stuff_last ? ST_IDLE : ST_BIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/fsk_tx_bit_framer.sv -----
// FSK transmit bit framer: turns character requests into line bits with tone and bit length.
// Each accepted request yields a run of line bits, one per transfer on the master side:
// async data and idle give 10 bits, sync flag and abort 8, sync data 8 to 10 with stuffed
// zeros; unknown operations give none. After a request is accepted, its line bits are paced
// by the single output register, which moves one bit per cycle while the downstream side
// keeps tready high; a new request is accepted the cycle after the last bit of the previous
// one enters that register.
// Write line_mode only while no request is in progress.
module fsk_tx_bit_framer import fsktx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write: line_mode
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  // Character requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  // Line bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] line_bit, [12:1] tone_hz, [23:13] samples_per_bit
  output logic        m_axis_tlast    // last_bit
);

  cmd_t        cmd;
  status_t     status;
  logic        line_bit;
  logic [11:0] tone_hz;
  logic [10:0] samples_per_bit;

  assign cfg_ready_o = 1'b1;

  fsktx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .operation_i (s_axis_tuser),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fsktx_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .operation_i       (s_axis_tuser),
    .data_byte_i       (s_axis_tdata),
    .cfg_we_i          (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .line_bit_o        (line_bit),
    .tone_hz_o         (tone_hz),
    .samples_per_bit_o (samples_per_bit),
    .last_bit_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {samples_per_bit, tone_hz, line_bit};

endmodule

// ----- tb/fsk_line_bit_checker.sv -----
// Checker for the FSK transmit bit framer: predicts every line bit and compares transfers.
`timescale 1ns / 100ps

module fsk_line_bit_checker import fsktx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_data_i,
  // Character request channel
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [7:0]  req_data_i,   // [7:0] data_byte
  input  logic [2:0]  req_op_i,     // [2:0] operation
  // Line bit channel
  input  logic        bit_valid_i,
  input  logic        bit_ready_i,
  input  logic [23:0] bit_data_i,   // [0] line_bit, [12:1] tone_hz, [23:13] samples_per_bit
  input  logic        bit_last_i,   // last_bit
  output int          mismatches_o,
  output int          pending_bits_o,
  output int          bits_checked_o
);

  typedef struct packed {
    logic        bit_val;
    logic [11:0] tone;
    logic [10:0] spb;
    logic        last;
  } line_bit_t;

  localparam int REPORT_LIMIT = 10;

  logic [2:0] line_mode_q;
  logic [4:0] stuff_history;
  line_bit_t  expected_bits[$];
  line_bit_t  got;
  line_bit_t  want;

  function automatic logic [7:0] msb_first(input logic [7:0] octet);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = octet[7 - i];
    return r;
  endfunction

  // Build one line bit from the current mode and shift it into the history
  function automatic line_bit_t next_line_bit(input logic b);
    line_bit_t   e;
    int unsigned bps;
    logic [11:0] space_hz;
    logic [11:0] mark_hz;
    case (line_mode_q)
      MODE_V21_ORIG: begin bps = 300;  space_hz = 12'd1180; mark_hz = 12'd980;  end
      MODE_V21_ANS:  begin bps = 300;  space_hz = 12'd1850; mark_hz = 12'd1650; end
      MODE_V23_ORIG: begin bps = 75;   space_hz = 12'd450;  mark_hz = 12'd390;  end
      // V23 answer, both 1200 bps modes, and unused codes saturated to the last entry
      default:       begin bps = 1200; space_hz = 12'd2100; mark_hz = 12'd1300; end
    endcase
    e.bit_val = b;
    e.tone    = b ? mark_hz : space_hz;
    e.spb     = 11'(SAMPLE_RATE / bps);
    e.last    = 1'b0;
    stuff_history = {stuff_history[3:0], b};
    return e;
  endfunction

  // Queue the run of line bits that one character request produces
  function automatic void predict_line_bits(input logic [2:0] op, input logic [7:0] octet);
    logic [9:0]  raw;
    int unsigned nraw;
    logic        stuffing;
    line_bit_t   run[$];
    line_bit_t   tail;
    raw = '0;
    nraw = 0;
    stuffing = 1'b0;
    case (op)
      OP_ASYNC_DATA: begin raw = {1'b1, octet, 1'b0}; nraw = 10; end
      OP_ASYNC_IDLE: begin raw = 10'h3ff; nraw = 10; end
      OP_SYNC_DATA:  begin raw = {2'b00, msb_first(octet)}; nraw = 8; stuffing = 1'b1; end
      OP_SYNC_FLAG:  begin raw = {2'b00, msb_first(8'h7e)}; nraw = 8; end
      OP_SYNC_ABORT: begin raw = {2'b00, msb_first(8'h7f)}; nraw = 8; end
      default:       nraw = 0;
    endcase
    for (int i = 0; i < nraw; i++) begin
      run.push_back(next_line_bit(raw[i]));
      // zero insertion after five ones in a row, stuffed bits included in the history
      if (stuffing && stuff_history == 5'h1f) run.push_back(next_line_bit(1'b0));
    end
    if (run.size() != 0) begin
      tail = run.pop_back();
      tail.last = 1'b1;
      run.push_back(tail);
    end
    foreach (run[k]) expected_bits.push_back(run[k]);
  endfunction

  // Track configuration and requests, compare every line bit transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q    = '0;
      stuff_history  = '0;
      expected_bits.delete();
      mismatches_o   = 0;
      pending_bits_o = 0;
      bits_checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) line_mode_q = cfg_data_i;
      if (req_valid_i && req_ready_i) predict_line_bits(req_op_i, req_data_i);
      if (bit_valid_i && bit_ready_i) begin
        got = '{bit_val: bit_data_i[0], tone: bit_data_i[12:1], spb: bit_data_i[23:13],
                last: bit_last_i};
        bits_checked_o++;
        if (expected_bits.size() == 0) begin
          if (mismatches_o < REPORT_LIMIT)
            $display("%0t: unexpected line bit: bit=%0b tone=%0d spb=%0d last=%0b",
                     $time, got.bit_val, got.tone, got.spb, got.last);
          mismatches_o++;
        end else begin
          want = expected_bits.pop_front();
          if (got.bit_val !== want.bit_val || got.tone !== want.tone ||
              got.spb !== want.spb || got.last !== want.last) begin
            if (mismatches_o < REPORT_LIMIT)
              $display({"%0t: line bit %0d mismatch: expected bit=%0b tone=%0d spb=%0d ",
                        "last=%0b, got bit=%0b tone=%0d spb=%0d last=%0b"},
                       $time, bits_checked_o, want.bit_val, want.tone, want.spb,
                       want.last, got.bit_val, got.tone, got.spb, got.last);
            mismatches_o++;
          end
        end
      end
      pending_bits_o = expected_bits.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the FSK transmit bit framer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import fsktx_pkg::*;

  // Line mode codes beyond the named ones, and operation codes the block ignores
  localparam logic [2:0] MODE_V23_ANS   = 3'd3;
  localparam logic [2:0] MODE_1200_A    = 3'd4;
  localparam logic [2:0] MODE_1200_B    = 3'd5;
  localparam logic [2:0] MODE_UNUSED_6  = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7  = 3'd7;
  localparam logic [2:0] OP_UNUSED_LO   = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID  = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI   = 3'd7;

  localparam int DRAIN_CYCLES   = 24;
  localparam int ITEMS_PER_MODE = 17;
  localparam int NUM_PHASES     = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [2:0]  s_axis_tuser;   // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;   // [0] line_bit, [12:1] tone_hz, [23:13] samples_per_bit
  logic        m_axis_tlast;   // last_bit

  int mismatches;
  int pending_bits;
  int bits_checked;
  int idle_odds = 4;
  int stall_left = 0;
  int chars_sent = 0;

  logic [2:0] mode_plan [NUM_PHASES] = '{MODE_UNUSED_7, MODE_V23_ORIG, MODE_1200_B,
                                         MODE_V21_ANS, MODE_UNUSED_6, MODE_V23_ANS,
                                         MODE_1200_A, MODE_V21_ORIG};

  fsk_tx_bit_framer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  fsk_line_bit_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_i    (s_axis_tready),
    .req_data_i     (s_axis_tdata),
    .req_op_i       (s_axis_tuser),
    .bit_valid_i    (m_axis_tvalid),
    .bit_ready_i    (m_axis_tready),
    .bit_data_i     (m_axis_tdata),
    .bit_last_i     (m_axis_tlast),
    .mismatches_o   (mismatches),
    .pending_bits_o (pending_bits),
    .bits_checked_o (bits_checked)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Stall the line bit side in random bursts
  always @(negedge clk_i) begin
    if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
      stall_left = $urandom_range(1, 14);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one character request, with an optional idle burst ahead of it
  task automatic send_request(input logic [2:0] op, input logic [7:0] octet);
    int gap;
    @(negedge clk_i);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 3'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= octet;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op <= 3'(OP_SYNC_ABORT)) chars_sent++;
  endtask

  // Drop the request side and wait until every expected bit has come out
  task automatic drain_line;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_bits != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_line_mode(input logic [2:0] mode);
    drain_line();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sync data biased toward long runs of ones so zero insertion fires often
  function automatic logic [7:0] ones_heavy_byte();
    logic [7:0] d;
    d = 8'($urandom);
    case ($urandom_range(0, 3))
      0:       return d;
      1:       return d | 8'hf0;
      2:       return d | 8'h1f;
      default: return 8'hff;
    endcase
  endfunction

  // One random burst: mostly HDLC-like frames, some async traffic, some ignored codes
  task automatic send_random_burst;
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      send_request(OP_SYNC_FLAG, 8'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) send_request(OP_SYNC_DATA, ones_heavy_byte());
      if ($urandom_range(0, 9) == 0) send_request(OP_SYNC_ABORT, 8'($urandom));
      else send_request(OP_SYNC_FLAG, 8'($urandom));
    end else if (kind < 88) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_request(OP_ASYNC_IDLE, 8'($urandom));
        else send_request(OP_ASYNC_DATA, 8'($urandom));
      end
    end else begin
      send_request(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom));
    end
  endtask

  initial begin
    int phase_start;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset line mode, field extremes, every operation and stuffing corners
    send_request(OP_ASYNC_DATA, 8'h00);
    send_request(OP_ASYNC_DATA, 8'hff);
    send_request(OP_ASYNC_DATA, 8'h55);
    send_request(OP_ASYNC_IDLE, 8'ha5);
    // history full of ones from idle: stuff right after the first data bit
    send_request(OP_SYNC_DATA, 8'h80);
    send_request(OP_SYNC_DATA, 8'h00);
    send_request(OP_SYNC_DATA, 8'hf8);
    send_request(OP_SYNC_DATA, 8'h3e);
    send_request(OP_SYNC_FLAG, 8'hff);
    send_request(OP_SYNC_DATA, 8'h7c);
    // abort leaves five ones behind: two stuffed zeros in the next byte
    send_request(OP_SYNC_ABORT, 8'h00);
    send_request(OP_SYNC_DATA, 8'hff);
    send_request(OP_SYNC_DATA, 8'hff);
    send_request(OP_SYNC_DATA, 8'h1f);
    send_request(OP_UNUSED_LO, 8'hff);
    send_request(OP_UNUSED_MID, 8'h00);
    send_request(OP_UNUSED_HI, 8'h5a);
    send_request(OP_SYNC_DATA, 8'h01);
    send_request(OP_SYNC_FLAG, 8'h00);
    send_request(OP_SYNC_ABORT, 8'hff);
    send_request(OP_ASYNC_DATA, 8'haa);

    // Random: one phase per line mode, no idling in the last one
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_line_mode(mode_plan[p]);
      // odds of one would stall the line side forever, so start at two
      idle_odds = (p == NUM_PHASES - 1) ? 0 : $urandom_range(2, 10);
      phase_start = chars_sent;
      while (chars_sent - phase_start < ITEMS_PER_MODE) send_random_burst();
    end

    drain_line();
    $display("Sent %0d character requests across %0d line mode settings; %0d line bits compared.",
             chars_sent, NUM_PHASES + 1, bits_checked);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d line bits differed from prediction", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #5_000_000;
    $display("Timed out with %0d line bits still expected", pending_bits);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fsktx_pkg.sv
rtl/fsktx_datapath.sv
rtl/fsktx_ctrl.sv
rtl/fsk_tx_bit_framer.sv
tb/fsk_line_bit_checker.sv
tb/testbench.sv
